>>> rtl/core/mrs_pkg.sv
// Shared constants, types and the CRC-16 step for the Modbus RTU register slave.
package mrs_pkg;

    localparam int FRAME_BYTES_DEF  = 512;
    localparam int PARAM_BYTES_DEF  = 1024;
    localparam int MAX_REG_ADDR_DEF = 256;

    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_LAST  = 2'd1;
    localparam logic [1:0] CMD_FETCH = 2'd2;

    localparam logic [7:0] FN_READ_REGS  = 8'h03;
    localparam logic [7:0] FN_WRITE_COIL = 8'h05;
    localparam logic [7:0] FN_WRITE_REG  = 8'h06;
    localparam logic [7:0] FN_WRITE_MULT = 8'h10;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [2:0] {
        ST_REPLY_READY = 3'd0,
        ST_BAD_ADDR    = 3'd1,
        ST_SHORT       = 3'd2,
        ST_WLEN_SHORT  = 3'd3,
        ST_UNSUPPORTED = 3'd4
    } t_status;

    typedef enum logic {
        KIND_STATUS = 1'b0,
        KIND_REPLY  = 1'b1
    } t_kind;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_HDR,
        S_DECODE,
        S_F3_FN,
        S_F3_CNT,
        S_F3_RD,
        S_F3_WR,
        S_F5_LO,
        S_F5_HI,
        S_F16_RD,
        S_F16_WR,
        S_SEAL,
        S_SEAL_LO,
        S_SEAL_HI,
        S_DONE,
        S_FETCH
    } t_state;

    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/core/mrs_chan_if.sv
// Request and result channel interfaces of the Modbus RTU register slave.
interface mrs_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;

    modport source(output valid, command, data_byte, input ready);
    modport sink(input valid, command, data_byte, output ready);
endinterface

interface mrs_res_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [2:0] status;
    logic       crc_ok;
    logic [8:0] reply_length;
    logic [7:0] reply_byte;
    logic       reply_last;

    modport source(output valid, result_kind, status, crc_ok, reply_length, reply_byte,
                   reply_last, input ready);
    modport sink(input valid, result_kind, status, crc_ok, reply_length, reply_byte,
                 reply_last, output ready);
endinterface

>>> rtl/core/mrs_ram.sv
// Single write port, single registered read port byte memory.
module mrs_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/core/modbus_rtu_register_slave.sv
// Modbus RTU holding-register slave: frame bytes are stored as they arrive. After the last
// byte a rejected request only reports its status; otherwise the data bytes are moved between
// the memories and the reply is sealed with its CRC. A fetch returns one reply byte. All of it
// is paced by the single read and write port of the frame and parameter memories. A result
// holds the request side off until it is taken. After reset the parameter memory is zeroed,
// one byte a cycle, and no request is taken meanwhile.
module modbus_rtu_register_slave #(
    parameter int FRAME_BYTES  = mrs_pkg::FRAME_BYTES_DEF,
    parameter int PARAM_BYTES  = mrs_pkg::PARAM_BYTES_DEF,
    parameter int MAX_REG_ADDR = mrs_pkg::MAX_REG_ADDR_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mrs_req_if.sink   i_req,
    mrs_res_if.source o_res
);
    import mrs_pkg::*;

    localparam int FIDX_W = $clog2(FRAME_BYTES);
    localparam int FCNT_W = $clog2(FRAME_BYTES + 1);
    localparam int PIDX_W = $clog2(PARAM_BYTES);
    localparam int PA_W   = $clog2(2 * MAX_REG_ADDR + 256);
    localparam int PSUM_W = (PA_W > PIDX_W) ? PA_W : PIDX_W;

    t_state              r_state, n_state;
    logic [FCNT_W-1:0]   r_cnt;
    logic [15:0]         r_crc;
    logic [8:0]          r_rcount;
    logic [8:0]          r_rptr;
    logic [8:0]          r_i;
    logic [47:0]         r_hdr;
    logic [PSUM_W-1:0]   r_base;
    logic [7:0]          r_more;
    logic [8:0]          r_rlen;
    t_status             r_status;
    logic                r_crc_ok;
    logic [15:0]         r_scrc;
    logic [PIDX_W-1:0]   r_clr;
    logic                r_pin;
    logic                r_ov;
    t_kind               r_okind;
    t_status             r_ostat;
    logic                r_ocrc;
    logic [8:0]          r_olen;
    logic [7:0]          r_obyte;
    logic                r_olast;

    logic                w_acc;
    logic [7:0]          w_fn;
    logic [15:0]         w_addr;
    logic [15:0]         w_range;
    logic [7:0]          w_more;
    logic [PSUM_W-1:0]   w_pa;
    logic                w_pin;
    logic                f_we;
    logic [FIDX_W-1:0]   f_waddr;
    logic [FIDX_W-1:0]   f_raddr;
    logic [7:0]          f_wdata;
    logic [7:0]          f_rdata;
    logic                p_we;
    logic [PIDX_W-1:0]   p_waddr;
    logic [7:0]          p_wdata;
    logic [7:0]          p_rdata;

    assign i_req.ready = (r_state == S_IDLE) && !r_ov;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_fn        = r_hdr[47:40];
    assign w_addr      = r_hdr[39:24];
    assign w_range     = r_hdr[23:8];
    assign w_more      = r_hdr[7:0];
    assign w_pa        = r_base + PSUM_W'(r_i);
    assign w_pin       = 32'(w_pa) < PARAM_BYTES;

    assign o_res.valid        = r_ov;
    assign o_res.result_kind  = r_okind;
    assign o_res.status       = r_ostat;
    assign o_res.crc_ok       = r_ocrc;
    assign o_res.reply_length = r_olen;
    assign o_res.reply_byte   = r_obyte;
    assign o_res.reply_last   = r_olast;

    mrs_ram #(.DEPTH(FRAME_BYTES), .WIDTH(8)) u_frame (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    mrs_ram #(.DEPTH(PARAM_BYTES), .WIDTH(8)) u_param (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (w_pa[PIDX_W-1:0]),
        .o_rdata (p_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == PIDX_W'(PARAM_BYTES - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_acc && i_req.command == CMD_LAST) begin
                    n_state = S_HDR;
                end else if (w_acc && i_req.command == CMD_FETCH && r_rptr < r_rcount) begin
                    n_state = S_FETCH;
                end
            end
            S_HDR: begin
                if (r_i == 9'd7) n_state = S_DECODE;
            end
            S_DECODE: begin
                priority if (w_addr > 16'(MAX_REG_ADDR)) n_state = S_DONE;
                else if (r_cnt < FCNT_W'(6)) n_state = S_DONE;
                else if (w_fn == FN_READ_REGS) n_state = S_F3_FN;
                else if (w_fn == FN_WRITE_COIL || w_fn == FN_WRITE_REG) n_state = S_F5_LO;
                else if (w_fn == FN_WRITE_MULT) begin
                    if (16'(r_cnt) < 16'd9 + 16'(w_more)) n_state = S_DONE;
                    else n_state = S_F16_RD;
                end
                else n_state = S_DONE;
            end
            S_F3_FN:   n_state = S_F3_CNT;
            S_F3_CNT:  n_state = S_F3_RD;
            S_F3_RD:   n_state = (r_i == 9'(r_more)) ? S_SEAL : S_F3_WR;
            S_F3_WR:   n_state = S_F3_RD;
            S_F5_LO:   n_state = S_F5_HI;
            S_F5_HI:   n_state = S_SEAL;
            S_F16_RD:  n_state = (r_i == 9'(r_more)) ? S_SEAL : S_F16_WR;
            S_F16_WR:  n_state = S_F16_RD;
            S_SEAL:    n_state = (r_i == r_rlen - 9'd2) ? S_SEAL_LO : S_SEAL;
            S_SEAL_LO: n_state = S_SEAL_HI;
            S_SEAL_HI: n_state = S_DONE;
            S_DONE:    n_state = S_IDLE;
            S_FETCH:   n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        f_we    = 1'b0;
        f_waddr = FIDX_W'(r_cnt);
        f_wdata = i_req.data_byte;
        f_raddr = FIDX_W'(r_rptr);
        p_we    = 1'b0;
        p_waddr = w_pa[PIDX_W-1:0];
        p_wdata = f_rdata;
        unique case (r_state)
            S_CLEAR: begin
                p_we    = 1'b1;
                p_waddr = r_clr;
                p_wdata = 8'h00;
            end
            S_IDLE: begin
                f_we = w_acc && (i_req.command == CMD_BYTE || i_req.command == CMD_LAST)
                       && (r_cnt < FCNT_W'(FRAME_BYTES));
            end
            S_HDR: begin
                f_raddr = FIDX_W'(r_i);
            end
            S_F3_FN: begin
                f_we    = 1'b1;
                f_waddr = FIDX_W'(1);
                f_wdata = FN_READ_REGS;
            end
            S_F3_CNT: begin
                f_we    = 1'b1;
                f_waddr = FIDX_W'(2);
                f_wdata = r_more;
            end
            S_F3_WR: begin
                f_we    = 1'b1;
                f_waddr = FIDX_W'(r_i) + FIDX_W'(3);
                f_wdata = r_pin ? p_rdata : 8'h00;
            end
            S_F5_LO: begin
                p_we    = w_pin;
                p_wdata = w_range[7:0];
            end
            S_F5_HI: begin
                p_we    = w_pin;
                p_wdata = w_range[15:8];
            end
            S_F16_RD: begin
                f_raddr = FIDX_W'(r_i) + FIDX_W'(7);
            end
            S_F16_WR: begin
                p_we = w_pin;
            end
            S_SEAL: begin
                f_raddr = FIDX_W'(r_i);
            end
            S_SEAL_LO: begin
                f_we    = 1'b1;
                f_waddr = FIDX_W'(r_rlen - 9'd2);
                f_wdata = r_scrc[7:0];
            end
            S_SEAL_HI: begin
                f_we    = 1'b1;
                f_waddr = FIDX_W'(r_rlen - 9'd1);
                f_wdata = r_scrc[15:8];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_crc    <= CRC_INIT;
            r_rcount <= '0;
            r_rptr   <= '0;
            r_i      <= '0;
            r_clr    <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ov && o_res.ready) r_ov <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + PIDX_W'(1);
                end
                S_IDLE: begin
                    if (w_acc && (i_req.command == CMD_BYTE || i_req.command == CMD_LAST)) begin
                        r_rcount <= '0;
                        r_rptr   <= '0;
                        if (r_cnt < FCNT_W'(FRAME_BYTES)) begin
                            r_cnt <= r_cnt + FCNT_W'(1);
                            r_crc <= crc_add(r_crc, i_req.data_byte);
                        end
                        r_i <= 9'd1;
                    end
                end
                S_HDR: begin
                    if (r_i >= 9'd2) r_hdr <= {r_hdr[39:0], f_rdata};
                    r_i <= r_i + 9'd1;
                end
                S_DECODE: begin
                    r_i      <= '0;
                    r_scrc   <= CRC_INIT;
                    r_crc_ok <= (r_cnt >= FCNT_W'(2)) && (r_crc == 16'h0000);
                    r_base   <= PSUM_W'({w_addr, 1'b0});
                    r_more   <= w_more;
                    r_rlen   <= 9'd8;
                    r_status <= ST_REPLY_READY;
                    priority if (w_addr > 16'(MAX_REG_ADDR)) begin
                        r_status <= ST_BAD_ADDR;
                        r_rlen   <= '0;
                    end else if (r_cnt < FCNT_W'(6)) begin
                        r_status <= ST_SHORT;
                        r_rlen   <= '0;
                    end else if (w_fn == FN_READ_REGS) begin
                        r_more <= {w_range[6:0], 1'b0};
                        r_rlen <= 9'({w_range[6:0], 1'b0}) + 9'd5;
                    end else if (w_fn == FN_WRITE_COIL || w_fn == FN_WRITE_REG) begin
                        r_rlen <= 9'd8;
                    end else if (w_fn == FN_WRITE_MULT) begin
                        if (16'(r_cnt) < 16'd9 + 16'(w_more)) begin
                            r_status <= ST_WLEN_SHORT;
                            r_rlen   <= '0;
                        end
                    end else begin
                        r_status <= ST_UNSUPPORTED;
                        r_rlen   <= '0;
                    end
                end
                S_F3_RD: begin
                    r_pin <= w_pin;
                    if (r_i == 9'(r_more)) r_i <= '0;
                end
                S_F3_WR, S_F16_WR, S_F5_LO: begin
                    r_i <= r_i + 9'd1;
                end
                S_F5_HI: begin
                    r_i <= '0;
                end
                S_F16_RD: begin
                    if (r_i == 9'(r_more)) r_i <= '0;
                end
                S_SEAL: begin
                    if (r_i != 9'd0) r_scrc <= crc_add(r_scrc, f_rdata);
                    r_i <= r_i + 9'd1;
                end
                S_DONE: begin
                    r_cnt    <= '0;
                    r_crc    <= CRC_INIT;
                    r_rptr   <= '0;
                    r_rcount <= r_rlen;
                    r_ov     <= 1'b1;
                end
                S_FETCH: begin
                    r_rptr <= r_rptr + 9'd1;
                    r_ov   <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            r_okind <= KIND_STATUS;
            r_ostat <= r_status;
            r_ocrc  <= r_crc_ok;
            r_olen  <= r_rlen;
            r_obyte <= 8'h00;
            r_olast <= 1'b0;
        end else if (r_state == S_FETCH) begin
            r_okind <= KIND_REPLY;
            r_ostat <= ST_REPLY_READY;
            r_ocrc  <= 1'b0;
            r_olen  <= r_rcount;
            r_obyte <= f_rdata;
            r_olast <= (r_rptr + 9'd1 == r_rcount);
        end
    end
endmodule

>>> sim/modbus_rtu_register_slave_checker.sv
// Channel monitor that predicts and checks every result of the Modbus RTU register slave.
`timescale 1ns / 100ps

module modbus_rtu_register_slave_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mrs_req_if    i_req,
    mrs_res_if    i_res,
    output int    o_fail_count,
    output int    o_pending
);
    import mrs_pkg::*;

    localparam int FRAME_SZ = FRAME_BYTES_DEF;
    localparam int PARAM_SZ = PARAM_BYTES_DEF;
    localparam int ADDR_MAX = MAX_REG_ADDR_DEF;

    typedef struct {
        t_kind       kind;
        t_status     status;
        logic        crc_ok;
        logic [8:0]  len;
        logic [7:0]  rbyte;
        logic        last;
    } t_slave_out;

    logic [7:0]  frame_mem [FRAME_SZ];
    logic [7:0]  param_mem [PARAM_SZ];
    int          rx_count;
    int          reply_len;
    int          reply_pos;
    logic [15:0] rx_crc;
    t_slave_out  reply_q [$];

    function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        return c;
    endfunction

    function automatic logic [7:0] frame_rd(int i);
        return (i < FRAME_SZ) ? frame_mem[i] : 8'h00;
    endfunction

    task automatic frame_wr(int i, logic [7:0] v);
        if (i < FRAME_SZ) frame_mem[i] = v;
    endtask

    function automatic logic [7:0] param_rd(int i);
        return (i < PARAM_SZ) ? param_mem[i] : 8'h00;
    endfunction

    task automatic param_wr(int i, logic [7:0] v);
        if (i < PARAM_SZ) param_mem[i] = v;
    endtask

    task automatic seal(int n);
        logic [15:0] c;
        c = 16'hFFFF;
        for (int i = 0; i + 2 < n; i++) c = crc_step(c, frame_rd(i));
        frame_wr(n - 2, c[7:0]);
        frame_wr(n - 1, c[15:8]);
    endtask

    task automatic take_byte(logic [7:0] b);
        reply_len = 0;
        reply_pos = 0;
        if (rx_count < FRAME_SZ) begin
            frame_mem[rx_count] = b;
            rx_count++;
            rx_crc = crc_step(rx_crc, b);
        end
    endtask

    task automatic close_frame();
        int          len;
        int          fn;
        int          addr;
        int          range;
        int          more;
        int          rlen;
        t_status     st;
        t_slave_out  r;
        len   = rx_count;
        fn    = frame_rd(1);
        addr  = {frame_rd(2), frame_rd(3)};
        range = {frame_rd(4), frame_rd(5)};
        more  = frame_rd(6);
        rlen  = 0;
        st    = ST_REPLY_READY;
        r.crc_ok = (len >= 2 && rx_crc == 16'h0000);
        if (addr > ADDR_MAX) begin
            st = ST_BAD_ADDR;
        end else if (len < 6) begin
            st = ST_SHORT;
        end else if (fn == FN_READ_REGS) begin
            more = (2 * range) & 8'hFF;
            frame_wr(1, FN_READ_REGS);
            frame_wr(2, more[7:0]);
            for (int i = 0; i < more; i++) frame_wr(3 + i, param_rd(2 * addr + i));
            rlen = more + 5;
            seal(rlen);
        end else if (fn == FN_WRITE_COIL || fn == FN_WRITE_REG) begin
            param_wr(2 * addr, range[7:0]);
            param_wr(2 * addr + 1, range[15:8]);
            rlen = 8;
            seal(rlen);
        end else if (fn == FN_WRITE_MULT) begin
            if (len < 9 + more) begin
                st = ST_WLEN_SHORT;
            end else begin
                for (int i = 0; i < more; i++) param_wr(2 * addr + i, frame_rd(7 + i));
                rlen = 8;
                seal(rlen);
            end
        end else begin
            st = ST_UNSUPPORTED;
        end
        rx_count  = 0;
        rx_crc    = 16'hFFFF;
        reply_pos = 0;
        reply_len = rlen;
        r.kind   = KIND_STATUS;
        r.status = st;
        r.len    = rlen[8:0];
        r.rbyte  = 8'h00;
        r.last   = 1'b0;
        reply_q.push_back(r);
    endtask

    task automatic predict(logic [1:0] cmd, logic [7:0] b);
        t_slave_out r;
        if (cmd == CMD_BYTE) begin
            take_byte(b);
        end else if (cmd == CMD_LAST) begin
            take_byte(b);
            close_frame();
        end else if (cmd == CMD_FETCH && reply_pos < reply_len) begin
            r.kind   = KIND_REPLY;
            r.status = ST_REPLY_READY;
            r.crc_ok = 1'b0;
            r.len    = reply_len[8:0];
            r.rbyte  = frame_rd(reply_pos);
            r.last   = (reply_pos + 1 == reply_len);
            reply_pos++;
            reply_q.push_back(r);
        end
    endtask

    task automatic compare_out();
        t_slave_out e;
        if (reply_q.size() == 0) begin
            $error("result with no expectation waiting");
            o_fail_count++;
            return;
        end
        e = reply_q.pop_front();
        if (i_res.result_kind !== e.kind) begin
            $error("result_kind expected %0d actual %0d", e.kind, i_res.result_kind);
            o_fail_count++;
        end
        if (i_res.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, i_res.status);
            o_fail_count++;
        end
        if (i_res.crc_ok !== e.crc_ok) begin
            $error("crc_ok expected %0d actual %0d", e.crc_ok, i_res.crc_ok);
            o_fail_count++;
        end
        if (i_res.reply_length !== e.len) begin
            $error("reply_length expected %0d actual %0d", e.len, i_res.reply_length);
            o_fail_count++;
        end
        if (i_res.reply_byte !== e.rbyte) begin
            $error("reply_byte expected %0d actual %0d", e.rbyte, i_res.reply_byte);
            o_fail_count++;
        end
        if (i_res.reply_last !== e.last) begin
            $error("reply_last expected %0d actual %0d", e.last, i_res.reply_last);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        rx_count     = 0;
        reply_len    = 0;
        reply_pos    = 0;
        rx_crc       = 16'hFFFF;
        for (int i = 0; i < PARAM_SZ; i++) param_mem[i] = 8'h00;
        for (int i = 0; i < FRAME_SZ; i++) frame_mem[i] = 8'h00;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1) compare_out();
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1)
                predict(i_req.command, i_req.data_byte);
            o_pending = reply_q.size();
        end
    end

endmodule

>>> sim/modbus_rtu_register_slave_test.sv
// Stimulus and verdict for the Modbus RTU register slave, with the checker beside the block.
`timescale 1ns / 100ps

module modbus_rtu_register_slave_test;
    import mrs_pkg::*;

    localparam int ITEM_TARGET = 1750;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_CYCLES = 800;
    localparam int HOLD_CYCLES = 2000;
    localparam int CRC_NONE = 0;
    localparam int CRC_GOOD = 1;
    localparam int CRC_BAD  = 2;
    localparam logic [1:0] CMD_NOP = 2'd3;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   sent;
    bit   busy_phase;
    bit   hold_req;

    mrs_req_if req();
    mrs_res_if res();

    modbus_rtu_register_slave dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_res   (res)
    );

    modbus_rtu_register_slave_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .i_res        (res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        res.ready = 1'b0;
        hold_req  = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                int gap;
                gap = busy_phase ? 0 : $urandom_range(0, 12);
                if (gap > 0) begin
                    res.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                res.ready <= 1'b1;
                do @(posedge i_clk); while (!(res.valid === 1'b1));
            end
        end
    end

    task automatic send_req(logic [1:0] cmd, logic [7:0] b);
        int gap;
        gap = busy_phase ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.valid     <= 1'b1;
        req.command   <= cmd;
        req.data_byte <= b;
        do @(posedge i_clk); while (!(req.ready === 1'b1));
        sent++;
    endtask

    task automatic send_frame(logic [7:0] q [$], int crc_mode, int fetches);
        logic [15:0] c;
        c = CRC_INIT;
        foreach (q[i]) c = crc_add(c, q[i]);
        if (crc_mode == CRC_BAD) c = c ^ (16'h0001 << $urandom_range(0, 15));
        if (crc_mode != CRC_NONE) begin
            q.push_back(c[7:0]);
            q.push_back(c[15:8]);
        end
        for (int i = 0; i < q.size(); i++)
            send_req((i == q.size() - 1) ? CMD_LAST : CMD_BYTE, q[i]);
        for (int i = 0; i < fetches; i++) send_req(CMD_FETCH, 8'($urandom));
    endtask

    function automatic void header(ref logic [7:0] q [$], input logic [7:0] fn, input int addr,
                                   input int rng);
        q = {8'($urandom), fn, 8'(addr >> 8), 8'(addr), 8'(rng >> 8), 8'(rng)};
    endfunction

    task automatic random_frame();
        logic [7:0] q [$];
        int pick;
        int addr;
        int rng;
        int more;
        int est;
        int nfetch;
        int crc_mode;
        pick     = $urandom_range(0, 99);
        addr     = $urandom_range(0, 256);
        rng      = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 12);
        crc_mode = ($urandom_range(0, 9) == 0) ? CRC_BAD : CRC_GOOD;
        est      = 8;
        if (pick < 30) begin
            header(q, FN_READ_REGS, addr, rng);
            est = ((2 * rng) & 255) + 5;
        end else if (pick < 50) begin
            header(q, FN_WRITE_REG, addr, $urandom_range(0, 65535));
        end else if (pick < 60) begin
            header(q, FN_WRITE_COIL, addr, $urandom_range(0, 65535));
        end else if (pick < 80) begin
            more = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 16);
            header(q, FN_WRITE_MULT, addr, $urandom_range(0, 65535));
            q.push_back(8'(more));
            if ($urandom_range(0, 7) == 0) begin
                more = (more > 0) ? $urandom_range(0, more - 1) : 0;
                crc_mode = CRC_NONE;
                est = 0;
            end
            repeat (more) q.push_back(8'($urandom));
        end else if (pick < 88) begin
            do pick = $urandom_range(0, 255);
            while (pick == FN_READ_REGS || pick == FN_WRITE_COIL || pick == FN_WRITE_REG
                   || pick == FN_WRITE_MULT);
            header(q, 8'(pick), addr, rng);
            est = 0;
        end else if (pick < 94) begin
            header(q, FN_READ_REGS, $urandom_range(257, 65535), rng);
            est = 0;
        end else begin
            repeat ($urandom_range(1, 5)) q.push_back(8'($urandom));
            crc_mode = CRC_NONE;
            est = 0;
        end
        nfetch = est + $urandom_range(0, 2);
        if ($urandom_range(0, 9) == 0) nfetch = $urandom_range(0, nfetch);
        send_frame(q, crc_mode, nfetch);
        if ($urandom_range(0, 19) == 0) send_req(CMD_NOP, 8'($urandom));
    endtask

    initial begin
        logic [7:0] q [$];
        int frames;
        req.valid     = 1'b0;
        req.command   = CMD_BYTE;
        req.data_byte = 8'h00;
        busy_phase    = 1'b0;
        sent          = 0;
        i_rst_n       = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        header(q, FN_WRITE_REG, 0, 16'hFFFF);
        send_frame(q, CRC_GOOD, 8);
        header(q, FN_READ_REGS, 0, 1);
        send_frame(q, CRC_GOOD, 8);
        header(q, FN_WRITE_MULT, 256, 0);
        q.push_back(8'd4);
        q = {q, 8'hFF, 8'h00, 8'hA5, 8'h5A};
        send_frame(q, CRC_GOOD, 9);
        header(q, FN_READ_REGS, 256, 128);
        send_frame(q, CRC_GOOD, 6);
        header(q, FN_READ_REGS, 255, 127);
        send_frame(q, CRC_GOOD, 260);
        header(q, FN_WRITE_COIL, 256, 16'h00FF);
        send_frame(q, CRC_BAD, 8);
        header(q, FN_READ_REGS, 16'hFFFF, 1);
        send_frame(q, CRC_GOOD, 1);
        header(q, FN_READ_REGS, 257, 0);
        send_frame(q, CRC_NONE, 0);
        q = {8'h01, FN_READ_REGS, 8'h00};
        send_frame(q, CRC_NONE, 1);
        q = {8'hFF};
        send_frame(q, CRC_NONE, 0);
        header(q, FN_WRITE_MULT, 1, 0);
        q.push_back(8'd10);
        send_frame(q, CRC_GOOD, 1);
        header(q, 8'h00, 0, 0);
        send_frame(q, CRC_GOOD, 0);
        header(q, 8'hFF, 0, 0);
        send_frame(q, CRC_GOOD, 0);
        send_req(CMD_NOP, 8'hFF);
        send_req(CMD_FETCH, 8'h00);
        header(q, FN_READ_REGS, 0, 2);
        send_frame(q, CRC_GOOD, 3);
        header(q, FN_WRITE_REG, 2, 16'h1234);
        send_frame(q, CRC_GOOD, 9);
        q.delete();
        repeat (515) q.push_back(8'($urandom));
        q[1] = FN_WRITE_REG;
        q[2] = 8'h00;
        send_frame(q, CRC_NONE, 9);

        frames = 0;
        while (sent < ITEM_TARGET) begin
            frames++;
            busy_phase = (frames % 17) < 3;
            if (frames == 12) hold_req = 1'b1;
            if (frames % 25 == 0) begin
                req.valid <= 1'b0;
                @(posedge i_clk);
                wait (pending == 0);
                @(posedge i_clk);
            end
            random_frame();
        end
        req.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/mrs_pkg.sv
rtl/core/mrs_chan_if.sv
rtl/core/mrs_ram.sv
rtl/core/modbus_rtu_register_slave.sv
sim/modbus_rtu_register_slave_checker.sv
sim/modbus_rtu_register_slave_test.sv
